>>> hw/rtl/bhfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// bhfs_pkg: widths, action codes and item types of the byte histogram unit
// used by every module and interface of the block; depends on nothing

package bhfs_pkg;

  localparam int SYM_W  = 8;
  localparam int NSYM   = 1 << SYM_W;
  localparam int DIST_W = SYM_W + 1;
  localparam int CNT_W  = 32;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ACT_COUNT = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // item held between the input register and the table update
  typedef struct packed {
    logic    vld;
    action_t act;
    sym_t    sym;
    sym_t    pos;
  } item_t;

  // registered read result
  typedef struct packed {
    logic  vld;
    sym_t  sym;
    cnt_t  cnt;
    logic  ent_vld;
    dist_t dist_tot;
  } res_t;

  function automatic logic is_space(input sym_t b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
           (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bhfs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// bhfs_in_if: input channel of the byte histogram unit
// depends on bhfs_pkg for field widths

interface bhfs_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [bhfs_pkg::SYM_W-1:0] byte_value;
  logic [bhfs_pkg::SYM_W-1:0] position;

  modport source (output valid, output action, output byte_value, output position,
                  input ready);
  modport sink   (input valid, input action, input byte_value, input position,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bhfs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// bhfs_out_if: result channel of the byte histogram unit
// depends on bhfs_pkg for field widths

interface bhfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [bhfs_pkg::SYM_W-1:0]  entry_symbol;
  logic [bhfs_pkg::CNT_W-1:0]  entry_count;
  logic                        entry_valid;
  logic [bhfs_pkg::DIST_W-1:0] distinct_symbols;

  modport source (output valid, output entry_symbol, output entry_count,
                  output entry_valid, output distinct_symbols, input ready);
  modport sink   (input valid, input entry_symbol, input entry_count,
                  input entry_valid, input distinct_symbols, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bhfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// bhfs_front: input register with action decode and whitespace filter
// depends on bhfs_pkg

module bhfs_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        advance,
  input  wire                        in_valid,
  input  wire [1:0]                  action,
  input  wire [bhfs_pkg::SYM_W-1:0]  byte_value,
  input  wire [bhfs_pkg::SYM_W-1:0]  position,
  input  wire                        skip_ws,
  output bhfs_pkg::item_t            s1_r
);

  bhfs_pkg::item_t item_nxt;

  always_comb begin
    item_nxt.vld = in_valid;
    item_nxt.act = bhfs_pkg::action_t'(action);
    item_nxt.sym = byte_value;
    item_nxt.pos = position;
    if (item_nxt.act == bhfs_pkg::ACT_NONE) begin
      item_nxt.vld = 1'b0;
    end
    // skipped whitespace leaves no trace
    if (item_nxt.act == bhfs_pkg::ACT_COUNT && skip_ws && bhfs_pkg::is_space(byte_value)) begin
      item_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (advance) begin
      s1_r.vld <= item_nxt.vld;
    end
    if (advance) begin
      s1_r.act <= item_nxt.act;
      s1_r.sym <= item_nxt.sym;
      s1_r.pos <= item_nxt.pos;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bhfs_table.sv
`timescale 1ns / 1ps
`default_nettype none
// bhfs_table: count and order memories, seen flags, distinct total, update and read path
// depends on bhfs_pkg; fed by bhfs_front

module bhfs_table (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        advance,
  input  wire [bhfs_pkg::SYM_W-1:0]  acc_sym,
  input  wire [bhfs_pkg::SYM_W-1:0]  acc_pos,
  input  wire bhfs_pkg::item_t       s1,
  output bhfs_pkg::res_t             res
);

  bhfs_pkg::cnt_t  cnt_mem [bhfs_pkg::NSYM];
  bhfs_pkg::sym_t  ord_mem [bhfs_pkg::NSYM];
  logic [bhfs_pkg::NSYM-1:0] seen_r;
  bhfs_pkg::dist_t dist_r;

  // accept-side read data with bypass of the update in flight
  bhfs_pkg::cnt_t  cnt_rd_r;
  logic            cnt_hit_r;
  bhfs_pkg::cnt_t  cnt_byp_r;
  bhfs_pkg::sym_t  ord_rd_r;
  logic            ord_hit_r;
  bhfs_pkg::sym_t  ord_byp_r;

  // result stage
  logic            s2_v_r;
  bhfs_pkg::sym_t  s2_sym_r;
  logic            s2_ok_r;
  bhfs_pkg::dist_t s2_dist_r;
  bhfs_pkg::cnt_t  s2_cnt_r;

  logic            s1_cnt;
  logic            s1_rd;
  logic            s1_clr;
  logic            seen_cur;
  logic            append;
  bhfs_pkg::cnt_t  cnt_old;
  bhfs_pkg::cnt_t  cnt_new;
  bhfs_pkg::sym_t  ord_sym;
  logic            in_range;

  always_comb begin
    s1_cnt   = s1.vld && (s1.act == bhfs_pkg::ACT_COUNT);
    s1_rd    = s1.vld && (s1.act == bhfs_pkg::ACT_READ);
    s1_clr   = s1.vld && (s1.act == bhfs_pkg::ACT_CLEAR);
    seen_cur = seen_r[s1.sym];
    append   = s1_cnt && !seen_cur && (dist_r != bhfs_pkg::dist_t'(bhfs_pkg::NSYM));
    cnt_old  = cnt_hit_r ? cnt_byp_r : cnt_rd_r;
    if (!seen_cur) begin
      cnt_new = bhfs_pkg::cnt_t'(1);
    end else if (cnt_old == '1) begin
      cnt_new = cnt_old;
    end else begin
      cnt_new = cnt_old + bhfs_pkg::cnt_t'(1);
    end
    ord_sym  = ord_hit_r ? ord_byp_r : ord_rd_r;
    in_range = {1'b0, s1.pos} < dist_r;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (advance && s1_cnt) begin
      cnt_mem[s1.sym] <= cnt_new;
    end
    if (advance && append) begin
      ord_mem[dist_r[bhfs_pkg::SYM_W-1:0]] <= s1.sym;
    end
  end

  // memory reads and bypass capture
  always_ff @(posedge clk) begin
    if (advance) begin
      cnt_rd_r  <= cnt_mem[acc_sym];
      cnt_byp_r <= cnt_new;
      ord_rd_r  <= ord_mem[acc_pos];
      ord_byp_r <= s1.sym;
      s2_cnt_r  <= cnt_mem[ord_sym];
      s2_sym_r  <= ord_sym;
      s2_ok_r   <= in_range;
      s2_dist_r <= dist_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      dist_r    <= '0;
      cnt_hit_r <= 1'b0;
      ord_hit_r <= 1'b0;
      s2_v_r    <= 1'b0;
    end else if (advance) begin
      cnt_hit_r <= s1_cnt && (s1.sym == acc_sym);
      ord_hit_r <= append && (dist_r[bhfs_pkg::SYM_W-1:0] == acc_pos);
      s2_v_r    <= s1_rd;
      if (s1_cnt) begin
        seen_r[s1.sym] <= 1'b1;
      end
      if (append) begin
        dist_r <= dist_r + bhfs_pkg::dist_t'(1);
      end
      if (s1_clr) begin
        seen_r <= '0;
        dist_r <= '0;
      end
    end
  end

  always_comb begin
    res.vld      = s2_v_r;
    res.sym      = s2_ok_r ? s2_sym_r : '0;
    res.cnt      = s2_ok_r ? s2_cnt_r : '0;
    res.ent_vld  = s2_ok_r;
    res.dist_tot = s2_dist_r;
  end

endmodule

`default_nettype wire

>>> hw/rtl/byte_histogram_first_seen_order_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// byte_histogram_first_seen_order_unit: top level of the byte histogram unit
// depends on bhfs_pkg, bhfs_in_if, bhfs_out_if, bhfs_front and bhfs_table

// Counts each byte value and keeps the distinct values in first-seen order.
// One transaction is taken every cycle unless input is held off: an input
// register, table update and memory lookup, then the result register that
// drives the output channel. A read result is valid once it reaches the
// result register. Input is held off only while a read result waits in the
// result register and the output side is not ready. No clearing pass is
// needed after reset; a clear empties the table. Counters saturate at all ones.

module byte_histogram_first_seen_order_unit (
  input  wire         clk,
  input  wire         rst_n,
  bhfs_in_if.sink     in_ch,
  bhfs_out_if.source  out_ch,
  input  wire         cfg_we,
  input  wire         cfg_wdata
);

  logic            skip_ws_r;
  logic            advance;
  bhfs_pkg::item_t s1_item;
  bhfs_pkg::res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_ws_r <= 1'b1;
    end else if (cfg_we) begin
      skip_ws_r <= cfg_wdata;
    end
  end

  assign advance     = !(res.vld && !out_ch.ready);
  assign in_ch.ready = advance;

  bhfs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_valid   (in_ch.valid),
    .action     (in_ch.action),
    .byte_value (in_ch.byte_value),
    .position   (in_ch.position),
    .skip_ws    (skip_ws_r),
    .s1_r       (s1_item)
  );

  bhfs_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .acc_sym (in_ch.byte_value),
    .acc_pos (in_ch.position),
    .s1      (s1_item),
    .res     (res)
  );

  assign out_ch.valid            = res.vld;
  assign out_ch.entry_symbol     = res.sym;
  assign out_ch.entry_count      = res.cnt;
  assign out_ch.entry_valid      = res.ent_vld;
  assign out_ch.distinct_symbols = res.dist_tot;

`ifndef ASSERT_OFF
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_item.vld && (s1_item.act == bhfs_pkg::ACT_READ) && advance |=> out_ch.valid)
    else $error("read transaction produced no result");

  a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.distinct_symbols <= bhfs_pkg::dist_t'(bhfs_pkg::NSYM))
    else $error("distinct count above symbol range");

  a_valid_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.entry_valid |-> out_ch.distinct_symbols != '0)
    else $error("valid entry reported from empty table");
`endif

endmodule

`default_nettype wire
